>>> design/scrolling_text_column_generator_unit_macros.svh
// assertion macros for the scrolling text column generator
`ifndef SCROLLING_TEXT_COLUMN_GENERATOR_UNIT_MACROS_SVH
`define SCROLLING_TEXT_COLUMN_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define SCRL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrl assertion failed: same cycle check");

`define SCRL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrl assertion failed: next cycle check");

`else

`define SCRL_ASSERT_NOW(lbl, ante, cons)

`define SCRL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/scrl_pkg.sv
// shared types, constants and font table of the scrolling text column generator
`default_nettype none

package scrl_pkg;

    localparam int TEXT_DEPTH = 64;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [2:0]        GLYPH_COLS   = 3'd5;
    localparam logic signed [10:0] WRAP_POS    = 11'sd20;
    localparam logic signed [9:0] WRAP_TARGET  = -10'sd5;
    localparam logic signed [9:0] RESTART_POS  = -10'sd1;
    localparam logic [9:0]        RECIP_SIX    = 10'd683;

    localparam logic [5:0] GLYPH_SPACE  = 6'd26;
    localparam logic [5:0] GLYPH_DIGIT0 = 6'd27;
    localparam logic [5:0] GLYPH_QMARK  = 6'd37;

    typedef struct packed {
        logic             wr_ok;
        logic             is_read;
        logic             show;
        logic [2:0]       gcol;
        logic [6:0]       char_num;
        logic signed [9:0] pos_next;
        logic             wrapped;
    } scrl_item_t;

    localparam logic [6:0] FONT_TABLE [0:37][0:4] = '{
        '{7'd63, 7'd68, 7'd68, 7'd68, 7'd63},
        '{7'd127, 7'd73, 7'd73, 7'd73, 7'd54},
        '{7'd62, 7'd65, 7'd65, 7'd65, 7'd34},
        '{7'd127, 7'd65, 7'd65, 7'd65, 7'd62},
        '{7'd127, 7'd73, 7'd73, 7'd73, 7'd73},
        '{7'd127, 7'd72, 7'd72, 7'd72, 7'd72},
        '{7'd62, 7'd65, 7'd65, 7'd69, 7'd39},
        '{7'd127, 7'd8, 7'd8, 7'd8, 7'd127},
        '{7'd65, 7'd65, 7'd127, 7'd65, 7'd65},
        '{7'd2, 7'd5, 7'd1, 7'd1, 7'd126},
        '{7'd127, 7'd8, 7'd20, 7'd34, 7'd65},
        '{7'd127, 7'd1, 7'd1, 7'd1, 7'd1},
        '{7'd127, 7'd32, 7'd16, 7'd32, 7'd127},
        '{7'd127, 7'd48, 7'd8, 7'd6, 7'd127},
        '{7'd127, 7'd65, 7'd65, 7'd65, 7'd127},
        '{7'd127, 7'd72, 7'd72, 7'd72, 7'd48},
        '{7'd126, 7'd66, 7'd70, 7'd66, 7'd127},
        '{7'd127, 7'd72, 7'd76, 7'd74, 7'd49},
        '{7'd49, 7'd73, 7'd73, 7'd73, 7'd70},
        '{7'd64, 7'd64, 7'd127, 7'd64, 7'd64},
        '{7'd126, 7'd1, 7'd1, 7'd1, 7'd126},
        '{7'd124, 7'd6, 7'd1, 7'd6, 7'd124},
        '{7'd124, 7'd3, 7'd124, 7'd3, 7'd124},
        '{7'd65, 7'd54, 7'd8, 7'd54, 7'd65},
        '{7'd64, 7'd32, 7'd31, 7'd32, 7'd64},
        '{7'd67, 7'd69, 7'd73, 7'd81, 7'd97},
        '{7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
        '{7'd127, 7'd67, 7'd93, 7'd97, 7'd127},
        '{7'd33, 7'd65, 7'd127, 7'd1, 7'd1},
        '{7'd38, 7'd73, 7'd73, 7'd73, 7'd49},
        '{7'd34, 7'd73, 7'd73, 7'd73, 7'd54},
        '{7'd28, 7'd36, 7'd79, 7'd4, 7'd4},
        '{7'd121, 7'd73, 7'd73, 7'd73, 7'd79},
        '{7'd127, 7'd73, 7'd73, 7'd73, 7'd79},
        '{7'd65, 7'd66, 7'd76, 7'd80, 7'd96},
        '{7'd127, 7'd73, 7'd73, 7'd73, 7'd127},
        '{7'd121, 7'd73, 7'd73, 7'd73, 7'd127},
        '{7'd32, 7'd64, 7'd77, 7'd80, 7'd32}
    };

    function automatic logic [5:0] glyph_of(input logic [7:0] code);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (code >= 8'h41 && code <= 8'h5A)
            begin
                diff = code - 8'h41;
                glyph_of = diff[5:0];
            end
            else if (code >= 8'h30 && code <= 8'h39)
            begin
                diff = code - 8'h30;
                glyph_of = GLYPH_DIGIT0 + diff[5:0];
            end
            else if (code == 8'h20)
            begin
                glyph_of = GLYPH_SPACE;
            end
            else
            begin
                glyph_of = GLYPH_QMARK;
            end
        end
    endfunction

    function automatic logic [6:0] font_column(input logic [7:0] code, input logic [2:0] gcol);
        begin
            if (gcol < GLYPH_COLS)
                font_column = FONT_TABLE[glyph_of(code)][gcol];
            else
                font_column = 7'd0;
        end
    endfunction

endpackage

`default_nettype wire

>>> design/scrl_text_mem.sv
// character store, one write and one registered read port
`default_nettype none

module scrl_text_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> design/scrl_scroll_ctrl.sv
// scroll offset and text length state, request decode and column arithmetic
`default_nettype none
`include "scrolling_text_column_generator_unit_macros.svh"

module scrl_scroll_ctrl #(
    parameter int MAX_TEXT = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [1:0]       func,
    input  wire logic [5:0]       char_index,
    input  wire logic             last_char,
    input  wire logic [3:0]       column,
    output scrl_pkg::scrl_item_t  item
);

    import scrl_pkg::*;

    localparam logic [8:0] MAX_TEXT_W = 9'(MAX_TEXT);

    logic signed [9:0] offset_reg;
    logic signed [9:0] offset_next;
    logic [6:0]        length_reg;
    logic [6:0]        length_next;

    logic signed [9:0]  off_inc;
    logic [6:0]         len_m1;
    logic [8:0]         span;
    logic signed [10:0] wrap_at;
    logic               wrap_hit;
    logic               idx_ok;
    logic signed [10:0] u;
    logic [8:0]         un;
    logic [18:0]        prod;
    logic [6:0]         k;
    logic [8:0]         k_six;
    logic [8:0]         g_full;
    logic [2:0]         g;

    always_comb
    begin
        off_inc  = offset_reg + 10'sd1;
        len_m1   = (length_reg == 7'd0) ? 7'd0 : length_reg - 7'd1;
        span     = {len_m1, 2'b00} + {1'b0, len_m1, 1'b0};
        wrap_at  = WRAP_POS + signed'({2'b00, span});
        wrap_hit = ({off_inc[9], off_inc} == wrap_at);
        idx_ok   = ({3'b000, char_index} < MAX_TEXT_W);

        u        = {offset_reg[9], offset_reg} - signed'({7'd0, column});
        un       = u[8:0];
        prod     = un * RECIP_SIX;
        k        = prod[18:12];
        k_six    = {k, 2'b00} + {1'b0, k, 1'b0};
        g_full   = un - k_six;
        g        = g_full[2:0];

        offset_next  = offset_reg;
        length_next  = length_reg;
        item.wr_ok    = 1'b0;
        item.is_read  = 1'b0;
        item.wrapped  = 1'b0;
        item.gcol     = g;
        item.char_num = k;
        item.show     = !u[10] && (g < GLYPH_COLS) && (k < length_reg)
                        && ({2'b00, k} < MAX_TEXT_W);

        unique case (func)
            FUNC_WRITE:
            begin
                item.wr_ok = idx_ok;
                if (idx_ok && last_char)
                begin
                    length_next = {1'b0, char_index} + 7'd1;
                    offset_next = RESTART_POS;
                end
            end
            FUNC_TICK:
            begin
                if (wrap_hit)
                begin
                    offset_next  = WRAP_TARGET;
                    item.wrapped = 1'b1;
                end
                else
                begin
                    offset_next = off_inc;
                end
            end
            FUNC_READ:
            begin
                item.is_read = 1'b1;
            end
            default:
            begin
            end
        endcase

        item.pos_next = offset_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= RESTART_POS;
            length_reg <= 7'd0;
        end
        else if (accept)
        begin
            offset_reg <= offset_next;
            length_reg <= length_next;
        end
    end

    `SCRL_ASSERT_NOW(a_length_bound, 1'b1, {2'b00, length_reg} <= MAX_TEXT_W)
    `SCRL_ASSERT_NEXT(a_last_restart, accept && func == FUNC_WRITE && last_char && idx_ok, offset_reg == RESTART_POS && length_reg == {1'b0, $past(char_index)} + 7'd1)
    `SCRL_ASSERT_NEXT(a_wrap_target, accept && item.wrapped, offset_reg == WRAP_TARGET)

endmodule

`default_nettype wire

>>> design/scrolling_text_column_generator_unit.sv
// top level: request decode, character store read, font lookup and result register
// datapath: a taken request enters the read stage (store read), then the font lookup loads the result register
// throughput: one request per cycle while results are taken, set by the single store read port
// a stalled result holds the read stage; requests stop once both stages are full
// reset: asynchronous, offset -1 and text length 0; the character store is not cleared
`default_nettype none
`include "scrolling_text_column_generator_unit_macros.svh"

module scrolling_text_column_generator_unit #(
    parameter int MAX_TEXT = scrl_pkg::TEXT_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  func,
    input  wire logic [5:0]  char_index,
    input  wire logic [7:0]  char_code,
    input  wire logic        last_char,
    input  wire logic [3:0]  column,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [6:0]       row_bits,
    output logic signed [9:0] scroll_position,
    output logic             wrapped
);

    import scrl_pkg::*;

    localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;

    scrl_item_t item;
    logic       accept;
    logic       s1_adv;
    logic [7:0] rd_data;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_read_reg;
    logic              s1_show_reg;
    logic [2:0]        s1_gcol_reg;
    logic signed [9:0] s1_pos_reg;
    logic              s1_wrap_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [6:0]        out_rows_reg;
    logic signed [9:0] out_pos_reg;
    logic              out_wrap_reg;
    logic              out_read_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;

    scrl_scroll_ctrl #(
        .MAX_TEXT(MAX_TEXT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (func),
        .char_index(char_index),
        .last_char (last_char),
        .column    (column),
        .item      (item)
    );

    scrl_text_mem #(
        .DEPTH(MAX_TEXT),
        .AW   (AW)
    ) u_mem (
        .clk    (clk),
        .wr_en  (accept && item.wr_ok),
        .wr_addr(AW'(char_index)),
        .wr_data(char_code),
        .rd_en  (accept && item.is_read),
        .rd_addr(AW'(item.char_num)),
        .rd_data(rd_data)
    );

    always_comb
    begin
        s1_valid_next = accept || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_read_reg <= item.is_read;
            s1_show_reg <= item.is_read && item.show;
            s1_gcol_reg <= item.gcol;
            s1_pos_reg  <= item.pos_next;
            s1_wrap_reg <= item.wrapped;
        end
        if (s1_adv)
        begin
            out_rows_reg <= s1_show_reg ? font_column(rd_data, s1_gcol_reg) : 7'd0;
            out_pos_reg  <= s1_pos_reg;
            out_wrap_reg <= s1_wrap_reg;
            out_read_reg <= s1_read_reg;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign row_bits        = out_rows_reg;
    assign scroll_position = out_pos_reg;
    assign wrapped         = out_wrap_reg;

    `SCRL_ASSERT_NOW(a_wrap_pos, out_valid_reg && out_wrap_reg, out_pos_reg == WRAP_TARGET)
    `SCRL_ASSERT_NOW(a_rows_read_only, out_valid_reg && out_rows_reg != 7'd0, out_read_reg && !out_wrap_reg)
    `SCRL_ASSERT_NEXT(a_s1_drains, s1_valid_reg && !out_valid_reg, out_valid_reg)

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// self-checking testbench for the scrolling text column generator unit
module testbench;

    import scrl_pkg::FUNC_WRITE;
    import scrl_pkg::FUNC_TICK;
    import scrl_pkg::FUNC_READ;

    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int CHAR_PITCH  = 6;
    localparam int GLYPH_WIDTH = 5;
    localparam int WRAP_AT     = 20;
    localparam logic signed [9:0] WRAP_TO    = -10'sd5;
    localparam logic signed [9:0] RESTART_AT = -10'sd1;

    localparam int GLYPH_BLANK  = 26;
    localparam int GLYPH_DIGITS = 27;
    localparam int GLYPH_QUERY  = 37;

    localparam logic [7:0] CODE_A     = 8'h41;
    localparam logic [7:0] CODE_Z     = 8'h5A;
    localparam logic [7:0] CODE_ZERO  = 8'h30;
    localparam logic [7:0] CODE_NINE  = 8'h39;
    localparam logic [7:0] CODE_SPACE = 8'h20;
    localparam logic [7:0] CODE_QUERY = 8'h3F;

    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    // A-Z, space, 0-9, question mark; five columns each, row bits per column
    localparam bit [0:37][0:4][6:0] font_cols = {
        7'd63, 7'd68, 7'd68, 7'd68, 7'd63,      7'd127, 7'd73, 7'd73, 7'd73, 7'd54,
        7'd62, 7'd65, 7'd65, 7'd65, 7'd34,      7'd127, 7'd65, 7'd65, 7'd65, 7'd62,
        7'd127, 7'd73, 7'd73, 7'd73, 7'd73,     7'd127, 7'd72, 7'd72, 7'd72, 7'd72,
        7'd62, 7'd65, 7'd65, 7'd69, 7'd39,      7'd127, 7'd8, 7'd8, 7'd8, 7'd127,
        7'd65, 7'd65, 7'd127, 7'd65, 7'd65,     7'd2, 7'd5, 7'd1, 7'd1, 7'd126,
        7'd127, 7'd8, 7'd20, 7'd34, 7'd65,      7'd127, 7'd1, 7'd1, 7'd1, 7'd1,
        7'd127, 7'd32, 7'd16, 7'd32, 7'd127,    7'd127, 7'd48, 7'd8, 7'd6, 7'd127,
        7'd127, 7'd65, 7'd65, 7'd65, 7'd127,    7'd127, 7'd72, 7'd72, 7'd72, 7'd48,
        7'd126, 7'd66, 7'd70, 7'd66, 7'd127,    7'd127, 7'd72, 7'd76, 7'd74, 7'd49,
        7'd49, 7'd73, 7'd73, 7'd73, 7'd70,      7'd64, 7'd64, 7'd127, 7'd64, 7'd64,
        7'd126, 7'd1, 7'd1, 7'd1, 7'd126,       7'd124, 7'd6, 7'd1, 7'd6, 7'd124,
        7'd124, 7'd3, 7'd124, 7'd3, 7'd124,     7'd65, 7'd54, 7'd8, 7'd54, 7'd65,
        7'd64, 7'd32, 7'd31, 7'd32, 7'd64,      7'd67, 7'd69, 7'd73, 7'd81, 7'd97,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
        7'd127, 7'd67, 7'd93, 7'd97, 7'd127,    7'd33, 7'd65, 7'd127, 7'd1, 7'd1,
        7'd38, 7'd73, 7'd73, 7'd73, 7'd49,      7'd34, 7'd73, 7'd73, 7'd73, 7'd54,
        7'd28, 7'd36, 7'd79, 7'd4, 7'd4,        7'd121, 7'd73, 7'd73, 7'd73, 7'd79,
        7'd127, 7'd73, 7'd73, 7'd73, 7'd79,     7'd65, 7'd66, 7'd76, 7'd80, 7'd96,
        7'd127, 7'd73, 7'd73, 7'd73, 7'd127,    7'd121, 7'd73, 7'd73, 7'd73, 7'd127,
        7'd32, 7'd64, 7'd77, 7'd80, 7'd32
    };

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] char_index;
        logic [7:0] char_code;
        logic       last_char;
        logic [3:0] column;
    } marquee_request_t;

    typedef struct packed {
        logic [6:0]        rows;
        logic signed [9:0] pos;
        logic              wrap;
    } column_result_t;

    typedef struct packed {
        marquee_request_t rq;
        int               reps;
        bit               typed;
        column_result_t   want;
    } script_row_t;

    localparam int SCRIPT_ROWS = 25;

    // typed rows: reset state, restarts, wraps and the first glyph column
    localparam script_row_t script [SCRIPT_ROWS] = '{
        '{'{FUNC_READ,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  -10'sd1, 1'b0}},
        '{'{FUNC_SPARE, 6'd63, 8'hFF, 1'b1, 4'd15}, 1,   1'b1, '{7'd0,  -10'sd1, 1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd63, 8'h5A, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd0,  8'h41, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd1,  8'hFF, 1'b0, 4'd0},  1,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd2,  8'h20, 1'b0, 4'd0},  1,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd3,  8'h39, 1'b0, 4'd0},  1,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd4,  8'h3F, 1'b0, 4'd0},  1,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_WRITE, 6'd5,  8'h00, 1'b1, 4'd0},  1,   1'b1, '{7'd0,  -10'sd1, 1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_READ,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd63, 10'sd0,  1'b0}},
        '{'{FUNC_READ,  6'd0,  8'h00, 1'b0, 4'd15}, 1,   1'b1, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  8,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_READ,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  41,  1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_READ,  6'd0,  8'h00, 1'b0, 4'd15}, 1,   1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  -10'sd5, 1'b1}},
        '{'{FUNC_READ,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  -10'sd5, 1'b0}},
        '{'{FUNC_WRITE, 6'd0,  8'h4D, 1'b1, 4'd0},  1,   1'b1, '{7'd0,  -10'sd1, 1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  20,  1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  -10'sd5, 1'b1}},
        '{'{FUNC_WRITE, 6'd63, 8'h3A, 1'b1, 4'd0},  1,   1'b1, '{7'd0,  -10'sd1, 1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  398, 1'b0, '{7'd0,  10'sd0,  1'b0}},
        '{'{FUNC_TICK,  6'd0,  8'h00, 1'b0, 4'd0},  1,   1'b1, '{7'd0,  -10'sd5, 1'b1}}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        func;
    logic [5:0]        char_index;
    logic [7:0]        char_code;
    logic              last_char;
    logic [3:0]        column;
    logic              rsp_valid;
    logic              rsp_ready;
    logic [6:0]        row_bits;
    logic signed [9:0] scroll_position;
    logic              wrapped;

    logic [7:0]        char_mem [64];
    bit   [63:0]       char_known;
    logic [6:0]        text_len;
    logic signed [9:0] scroll_pos;
    bit                wrapped_last;

    column_result_t    pending_columns [$];
    column_result_t    no_typed;
    int                mismatch_count;
    int                columns_received;
    int                requests_taken;
    int                burst_left;
    bit                hold_off;

    scrolling_text_column_generator_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .func            (func),
        .char_index      (char_index),
        .char_code       (char_code),
        .last_char       (last_char),
        .column          (column),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .row_bits        (row_bits),
        .scroll_position (scroll_position),
        .wrapped         (wrapped)
    );

    always #1 clk = ~clk;

    function automatic int glyph_index(input logic [7:0] code);
        if (code >= CODE_A && code <= CODE_Z)
            return int'(code) - int'(CODE_A);
        if (code >= CODE_ZERO && code <= CODE_NINE)
            return GLYPH_DIGITS + int'(code) - int'(CODE_ZERO);
        if (code == CODE_SPACE)
            return GLYPH_BLANK;
        return GLYPH_QUERY;
    endfunction

    task automatic scroll_and_scan(input marquee_request_t rq, output column_result_t res);
        int span;
        int u;
        res = '0;
        case (rq.func)
            FUNC_WRITE:
            begin
                char_mem[rq.char_index] = rq.char_code;
                char_known[rq.char_index] = 1'b1;
                if (rq.last_char)
                begin
                    text_len = {1'b0, rq.char_index} + 7'd1;
                    scroll_pos = RESTART_AT;
                end
            end
            FUNC_TICK:
            begin
                span = (text_len == 7'd0) ? 1 : int'(text_len);
                scroll_pos = scroll_pos + 10'sd1;
                if (int'(scroll_pos) - CHAR_PITCH * (span - 1) == WRAP_AT)
                begin
                    scroll_pos = WRAP_TO;
                    res.wrap = 1'b1;
                end
            end
            FUNC_READ:
            begin
                u = int'(scroll_pos) - int'(rq.column);
                if (u >= 0 && u % CHAR_PITCH < GLYPH_WIDTH && u / CHAR_PITCH < int'(text_len))
                    res.rows = font_cols[glyph_index(char_mem[u / CHAR_PITCH])][u % CHAR_PITCH];
            end
            default:
            begin
            end
        endcase
        res.pos = scroll_pos;
        wrapped_last = res.wrap;
    endtask

    // a read that would land on a character never written
    function automatic bit reads_unknown(input logic [3:0] col);
        int u;
        u = int'(scroll_pos) - int'(col);
        return u >= 0 && u / CHAR_PITCH < int'(text_len) && !char_known[u / CHAR_PITCH];
    endfunction

    function automatic marquee_request_t random_request();
        marquee_request_t rq;
        rq.func = FUNC_SPARE;
        rq.char_index = 6'($urandom);
        rq.char_code = 8'($urandom);
        rq.last_char = 1'($urandom);
        rq.column = 4'($urandom);
        return rq;
    endfunction

    function automatic logic [7:0] text_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return CODE_A + 8'($urandom_range(0, 25));
            6, 7: return CODE_ZERO + 8'($urandom_range(0, 9));
            8: return ($urandom_range(0, 1) != 0) ? CODE_SPACE : CODE_QUERY;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic marquee_request_t motion_request(input int read_pct);
        marquee_request_t rq;
        rq = random_request();
        rq.func = ($urandom_range(0, 99) < read_pct) ? FUNC_READ : FUNC_TICK;
        if (rq.func == FUNC_READ && reads_unknown(rq.column))
            rq.func = FUNC_TICK;
        return rq;
    endfunction

    task automatic offer(input marquee_request_t rq, input bit typed, input column_result_t want);
        column_result_t res;
        int gap;
        if (burst_left <= 0 && !hold_off)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        req_valid <= 1'b1;
        func <= rq.func;
        char_index <= rq.char_index;
        char_code <= rq.char_code;
        last_char <= rq.last_char;
        column <= rq.column;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
        scroll_and_scan(rq, res);
        pending_columns.push_back(typed ? want : res);
        if (rq.func != FUNC_SPARE)
            requests_taken++;
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_columns
        column_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            columns_received++;
            if (pending_columns.size() == 0)
                flag_mismatch("result with no request outstanding", int'(row_bits), 0);
            else
            begin
                want = pending_columns.pop_front();
                if (row_bits !== want.rows)
                    flag_mismatch("row_bits", int'(row_bits), int'(want.rows));
                if (scroll_position !== want.pos)
                    flag_mismatch("scroll_position", int'(scroll_position), int'(want.pos));
                if (wrapped !== want.wrap)
                    flag_mismatch("wrapped", int'(wrapped), int'(want.wrap));
            end
        end
    end

    initial
    begin : sink
        int cyc;
        int held;
        bit hold_done;
        cyc = 0;
        hold_done = 1'b0;
        rsp_ready = 1'b0;
        hold_off = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!hold_done && columns_received >= 600)
            begin
                // long stall so the pipeline fills and pushes back on requests
                hold_done = 1'b1;
                hold_off <= 1'b1;
                rsp_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
            else
            begin
                case ((cyc / 256) % 4)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ready <= (cyc % 7 != 3) && (cyc % 5 != 0);
                    default: rsp_ready <= 1'($urandom);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int r;
        int n;
        int steps;
        int base;
        int pick;
        marquee_request_t rq;
        rst_n = 1'b0;
        req_valid = 1'b0;
        func = FUNC_WRITE;
        char_index = 6'd0;
        char_code = 8'd0;
        last_char = 1'b0;
        column = 4'd0;
        no_typed = '0;
        char_known = '0;
        text_len = 7'd0;
        scroll_pos = RESTART_AT;
        wrapped_last = 1'b0;
        mismatch_count = 0;
        columns_received = 0;
        requests_taken = 0;
        burst_left = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < SCRIPT_ROWS; i++)
            for (r = 0; r < script[i].reps; r++)
                offer(script[i].rq, script[i].typed, script[i].want);

        base = requests_taken;
        while (requests_taken - base < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                // whole message, then a scroll-and-scan run over it
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                begin
                    rq = random_request();
                    rq.func = FUNC_WRITE;
                    rq.char_index = 6'(i);
                    rq.char_code = text_code();
                    rq.last_char = (i == n - 1);
                    offer(rq, 1'b0, no_typed);
                end
                steps = $urandom_range(10, 80);
                for (i = 0; i < steps; i++)
                    offer(motion_request(45), 1'b0, no_typed);
                if ($urandom_range(0, 3) == 0)
                begin
                    do
                        offer(motion_request(30), 1'b0, no_typed);
                    while (!wrapped_last);
                end
            end
            else if (pick == 7)
            begin
                rq = random_request();
                rq.func = FUNC_WRITE;
                rq.last_char = ($urandom_range(0, 3) == 0);
                offer(rq, 1'b0, no_typed);
            end
            else if (pick == 8)
                offer(random_request(), 1'b0, no_typed);
            else
                offer(motion_request(50), 1'b0, no_typed);
        end

        req_valid <= 1'b0;
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin : watchdog
        #1000000;
        $display("status: fail");
        $finish;
    end

endmodule
